@@ rtl/core/mfsd_pkg.sv @@
// ----------------------------------------------------------------------------
// mfsd_pkg
// Shared types, constants and the byte-wide crc update for the modbus frame
// status decoder.
// ----------------------------------------------------------------------------
package mfsd_pkg;

  // frame layout
  localparam int FRAME_BYTES  = 20;
  localparam int CELL_COUNT   = FRAME_BYTES - 1;
  localparam int POS_W        = $clog2(FRAME_BYTES);
  localparam int CRC_SPAN     = 18;

  // codes and thresholds
  localparam logic [7:0]  FUNC_COMMAND      = 8'h05;
  localparam logic [7:0]  COUNT_RESET_AT    = 8'd9;
  localparam logic [7:0]  COUNT_CLASSIFY_AT = 8'd3;
  localparam logic [7:0]  COUNT_MAX         = 8'hFF;
  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam logic [15:0] SPEED_LIMIT_RESET = 16'd62;

  typedef logic [7:0] byte_t;
  typedef logic [CELL_COUNT-1:0][7:0] cell_row_t;

  typedef enum logic [2:0] {
    ST_COMMAND    = 3'd0,
    ST_CRC_ERROR  = 3'd1,
    ST_NO_STATUS  = 3'd2,
    ST_STOPPED    = 3'd3,
    ST_OBSTRUCTED = 3'd4,
    ST_NORMAL     = 3'd5
  } frame_status_t;

  typedef struct packed {
    frame_status_t frame_status;
    byte_t         station_address;
    byte_t         function_code;
    byte_t         sequence_count;
  } frame_result_t;

  // reflected crc-16 update over one byte, lsb first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input byte_t b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/core/mfsd_cell.sv @@
// ----------------------------------------------------------------------------
// mfsd_cell
// One byte cell of the frame shift line; takes its neighbour's byte on shift.
// ----------------------------------------------------------------------------
module mfsd_cell (
  input  logic              clk,
  input  logic              shift_en,
  input  mfsd_pkg::byte_t   din,
  output mfsd_pkg::byte_t   dout
);
  import mfsd_pkg::*;

  byte_t held;

  // byte register, payload only
  always_ff @(posedge clk) begin
    if (shift_en) begin
      held <= din;
    end
  end

  assign dout = held;

endmodule

@@ rtl/core/mfsd_judge.sv @@
// ----------------------------------------------------------------------------
// mfsd_judge
// End-of-frame decision: sequence count update, crc check and motor status.
// ----------------------------------------------------------------------------
module mfsd_judge (
  input  mfsd_pkg::cell_row_t     cells,
  input  mfsd_pkg::byte_t         last_byte,
  input  logic [15:0]             crc,
  input  mfsd_pkg::byte_t         seq_count,
  input  mfsd_pkg::byte_t         prev_func,
  input  logic [15:0]             speed_limit,
  output mfsd_pkg::frame_result_t result,
  output mfsd_pkg::byte_t         seq_next
);
  import mfsd_pkg::*;

  // byte i of the frame sits in cell CELL_COUNT-1-i
  function automatic byte_t frame_byte(input cell_row_t row, input int i);
    return row[CELL_COUNT-1-i];
  endfunction

  byte_t         func;
  byte_t         seq_upd;
  logic [15:0]   rx_crc;
  logic [15:0]   w2;
  logic [15:0]   w3;
  logic [15:0]   w4;
  frame_status_t status;

  always_comb begin
    func   = frame_byte(cells, 1);
    rx_crc = {last_byte, frame_byte(cells, CRC_SPAN)};
    w2     = {frame_byte(cells, 5), frame_byte(cells, 6)};
    w3     = {frame_byte(cells, 7), frame_byte(cells, 8)};
    w4     = {frame_byte(cells, 9), frame_byte(cells, 10)};

    // sequence count update
    if (func == FUNC_COMMAND || prev_func == FUNC_COMMAND) begin
      seq_upd = 8'd1;
    end else if (seq_count != COUNT_MAX) begin
      seq_upd = seq_count + 8'd1;
    end else begin
      seq_upd = seq_count;
    end

    // status classification, first match wins
    if (func == FUNC_COMMAND) begin
      status = ST_COMMAND;
    end else if (rx_crc != crc) begin
      status = ST_CRC_ERROR;
    end else if (seq_upd < COUNT_CLASSIFY_AT) begin
      status = ST_NO_STATUS;
    end else if (w2 == 16'h0000 && w3 == 16'h0000 && w4 == 16'h0000) begin
      status = ST_STOPPED;
    end else if (frame_byte(cells, 11) != 8'h00) begin
      status = ST_OBSTRUCTED;
    end else if (w2 != 16'h0000 && w3 <= speed_limit) begin
      status = ST_NORMAL;
    end else begin
      status = ST_NO_STATUS;
    end

    // clear at nine or more after a good non-command frame
    if (status != ST_COMMAND && status != ST_CRC_ERROR && seq_upd >= COUNT_RESET_AT) begin
      seq_next = 8'd0;
    end else begin
      seq_next = seq_upd;
    end

    result.frame_status    = status;
    result.station_address = frame_byte(cells, 0);
    result.function_code   = func;
    result.sequence_count  = seq_upd;
  end

endmodule

@@ rtl/core/modbus_frame_status_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// modbus_frame_status_decoder_unit
// Gathers received bytes into 20-byte modbus frames and reports one status
// item per frame.
// ----------------------------------------------------------------------------
// One received byte is taken every clock cycle. Bytes shift through a row of
// nineteen byte cells while a byte-wide crc-16 update runs alongside; on the
// twentieth byte the frame is judged in the same cycle and the result item is
// registered, appearing on the output in the cycle after the last byte. The input
// stalls only on a frame's last byte, and only while the previous result item
// still sits in the output register and is not being taken. The speed limit
// register may be written at any time the block is idle and resets to 62.
module modbus_frame_status_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  // config write channel: normal_speed_limit
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  // input items: [7:0] rx_byte
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  // result items: [2:0] frame_status, [10:3] station_address,
  // [18:11] function_code, [26:19] sequence_count, [31:27] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata
);
  import mfsd_pkg::*;

  logic             in_acc;
  logic             pos_last;
  logic [POS_W-1:0] pos;
  logic [15:0]      crc;
  logic [15:0]      speed_limit;
  byte_t            seq_count;
  byte_t            prev_func;
  byte_t            seq_next;
  cell_row_t        cells;
  frame_result_t    judged;
  frame_result_t    out_item;

  assign pos_last      = (pos == POS_W'(FRAME_BYTES - 1));
  assign s_axis_tready = !pos_last || !m_axis_tvalid || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_limit <= SPEED_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      speed_limit <= cfg_data;
    end
  end

  // chain of byte cells, newest byte in cell 0
  for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
    byte_t cell_in;
    if (k == 0) begin : g_head
      assign cell_in = s_axis_tdata;
    end else begin : g_link
      assign cell_in = cells[k-1];
    end
    mfsd_cell u_cell (
      .clk      (clk),
      .shift_en (in_acc),
      .din      (cell_in),
      .dout     (cells[k])
    );
  end

  // end of frame decision
  mfsd_judge u_judge (
    .cells       (cells),
    .last_byte   (s_axis_tdata),
    .crc         (crc),
    .seq_count   (seq_count),
    .prev_func   (prev_func),
    .speed_limit (speed_limit),
    .result      (judged),
    .seq_next    (seq_next)
  );

  // byte position and running crc
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      crc <= CRC_INIT;
    end else if (in_acc) begin
      if (pos_last) begin
        pos <= '0;
        crc <= CRC_INIT;
      end else begin
        pos <= pos + POS_W'(1);
        if (pos < POS_W'(CRC_SPAN)) begin
          crc <= crc_feed(crc, s_axis_tdata);
        end
      end
    end
  end

  // sequence state, updated once per frame
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_count <= 8'd0;
      prev_func <= 8'd0;
    end else if (in_acc && pos_last) begin
      seq_count <= seq_next;
      prev_func <= judged.function_code;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_acc && pos_last) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && pos_last) begin
      out_item <= judged;
    end
  end

  assign m_axis_tdata = {5'b00000, out_item.sequence_count, out_item.function_code,
                         out_item.station_address, 3'(out_item.frame_status)};

  // checks
  a_rose_after_last: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(in_acc && pos_last))
    else $error("result item appeared without a completed frame");

  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    (in_acc && pos_last) |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result item overwritten before it was taken");

  a_crc_start: assert property (@(posedge clk) disable iff (rst)
    (pos == '0) |-> (crc == CRC_INIT))
    else $error("running crc not at its initial value at frame start");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (pos <= POS_W'(FRAME_BYTES - 1)))
    else $error("byte position beyond the frame");

endmodule

@@ test/modbus_status_checker.sv @@
// ----------------------------------------------------------------------------
// modbus_status_checker
// Watches the byte, result and speed limit channels of the frame status
// decoder, predicts the status item of every frame and compares each result
// item field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module modbus_status_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,  // [2:0] status, [10:3] station, [18:11] function,
                                     // [26:19] sequence count, [31:27] zero
  output int          fail_count,
  output int          reports_due
);
  timeunit 1ns;
  timeprecision 1ps;

  import mfsd_pkg::*;

  // predicted decoder state
  logic [4:0]    byte_slot;
  byte_t         frame_bytes [FRAME_BYTES];
  logic [15:0]   crc_acc;
  byte_t         seq_n;
  byte_t         last_function;
  logic [15:0]   speed_limit;
  frame_result_t status_reports [$];

  // one byte of the reflected crc-16, lsb first
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input byte_t b);
    logic [15:0] acc;
    acc = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
    end
    return acc;
  endfunction

  task automatic flag_fault(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  // take in one received byte, judge the frame on its last byte
  task automatic absorb_byte(input byte_t b);
    frame_result_t r;
    logic [15:0]   w_run, w_speed, w_aux, rx_crc;
    frame_bytes[byte_slot] = b;
    if (byte_slot < CRC_SPAN) crc_acc = crc_step(crc_acc, b);
    if (byte_slot != FRAME_BYTES - 1) begin
      byte_slot = byte_slot + 5'd1;
      return;
    end
    r.station_address = frame_bytes[0];
    r.function_code   = frame_bytes[1];
    if (frame_bytes[1] == FUNC_COMMAND) begin
      seq_n = 8'd1;
      r.frame_status = ST_COMMAND;
    end else begin
      if (last_function == FUNC_COMMAND) seq_n = 8'd1;
      else if (seq_n != COUNT_MAX) seq_n = seq_n + 8'd1;
      rx_crc = {frame_bytes[CRC_SPAN+1], frame_bytes[CRC_SPAN]};
      if (rx_crc != crc_acc) begin
        r.frame_status = ST_CRC_ERROR;
      end else begin
        r.frame_status = ST_NO_STATUS;
        if (seq_n >= COUNT_CLASSIFY_AT) begin
          w_run   = {frame_bytes[5], frame_bytes[6]};
          w_speed = {frame_bytes[7], frame_bytes[8]};
          w_aux   = {frame_bytes[9], frame_bytes[10]};
          if (w_run == 16'd0 && w_speed == 16'd0 && w_aux == 16'd0) begin
            r.frame_status = ST_STOPPED;
          end else if (frame_bytes[11] != 8'd0) begin
            r.frame_status = ST_OBSTRUCTED;
          end else if (w_run != 16'd0 && w_speed <= speed_limit) begin
            r.frame_status = ST_NORMAL;
          end
        end
      end
    end
    last_function    = frame_bytes[1];
    r.sequence_count = seq_n;
    // good non-command frame at nine or more clears the count
    if (r.frame_status >= ST_NO_STATUS && seq_n >= COUNT_RESET_AT) seq_n = 8'd0;
    status_reports.push_back(r);
    byte_slot = '0;
    crc_acc   = CRC_INIT;
  endtask

  // compare one result item with the oldest prediction
  task automatic check_report(input logic [31:0] d);
    frame_result_t want;
    if (status_reports.size() == 0) begin
      flag_fault($sformatf("result item %h with nothing expected", d));
      return;
    end
    want = status_reports.pop_front();
    if (d[2:0] != want.frame_status)
      flag_fault($sformatf("frame_status got %0d want %0d", d[2:0], want.frame_status));
    if (d[10:3] != want.station_address)
      flag_fault($sformatf("station_address got %h want %h", d[10:3], want.station_address));
    if (d[18:11] != want.function_code)
      flag_fault($sformatf("function_code got %h want %h", d[18:11], want.function_code));
    if (d[26:19] != want.sequence_count)
      flag_fault($sformatf("sequence_count got %0d want %0d", d[26:19], want.sequence_count));
    if (d[31:27] != 5'd0)
      flag_fault($sformatf("padding bits got %h", d[31:27]));
  endtask

  // sample every channel at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      byte_slot     = '0;
      crc_acc       = CRC_INIT;
      seq_n         = 8'd0;
      last_function = 8'd0;
      speed_limit   = SPEED_LIMIT_RESET;
      status_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) speed_limit = cfg_data;
      if (s_axis_tvalid && s_axis_tready) absorb_byte(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) check_report(m_axis_tdata);
    end
    reports_due = status_reports.size();
  end

endmodule

@@ test/tb_modbus_frame_status_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// tb_modbus_frame_status_decoder_unit
// Drives whole modbus frames of every kind into the decoder under several
// speed limits, with random idling on both sides, one long receiver hold-off
// and a run of crc errors that carries the count to eight or more, then gives the
// verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_modbus_frame_status_decoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import mfsd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 150;

  typedef enum int {
    FK_COMMAND, FK_BAD_CRC, FK_NOISE, FK_STOPPED, FK_OBSTRUCTED, FK_NORMAL, FK_SPEEDY
  } frame_kind_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [2:0] status, [10:3] station, [18:11] function,
                               // [26:19] sequence count, [31:27] zero
  int          fail_count;
  int          reports_due;
  int          cycles;
  logic        calm;
  logic        hold_req;
  logic [15:0] cur_limit;
  byte_t       frame [FRAME_BYTES];

  modbus_frame_status_decoder_unit uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  modbus_status_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .reports_due   (reports_due)
  );

  // clock and watchdog
  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin : receiver
    logic held;
    held = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
      m_axis_tready = 1'b1;
    end
  end

  // frame check sequence over the frame head
  function automatic logic [15:0] head_crc();
    logic [15:0] acc;
    acc = CRC_INIT;
    for (int i = 0; i < CRC_SPAN; i++) begin
      acc = acc ^ {8'h00, frame[i]};
      for (int k = 0; k < 8; k++) acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
    end
    return acc;
  endfunction

  function automatic byte_t plain_function();
    byte_t f;
    do f = 8'($urandom); while (f == FUNC_COMMAND);
    return f;
  endfunction

  function automatic frame_kind_t pick_kind();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8)  return FK_COMMAND;
    if (roll < 18) return FK_BAD_CRC;
    if (roll < 24) return FK_NOISE;
    if (roll < 42) return FK_STOPPED;
    if (roll < 60) return FK_OBSTRUCTED;
    if (roll < 85) return FK_NORMAL;
    return FK_SPEEDY;
  endfunction

  // random content shaped to one kind of frame
  task automatic build_frame(input frame_kind_t kind);
    logic [15:0] w;
    logic [15:0] crc;
    for (int i = 0; i < FRAME_BYTES; i++) frame[i] = 8'($urandom);
    if (kind == FK_NOISE) return;
    frame[1] = (kind == FK_COMMAND) ? FUNC_COMMAND : plain_function();
    case (kind)
      FK_STOPPED: begin
        for (int i = 5; i <= 10; i++) frame[i] = 8'h00;
      end
      FK_OBSTRUCTED: begin
        frame[11] = 8'($urandom_range(1, 255));
      end
      FK_NORMAL, FK_SPEEDY: begin
        frame[11] = 8'h00;
        frame[6]  = 8'($urandom_range(1, 255));
        if (kind == FK_NORMAL)
          w = ($urandom_range(0, 3) == 0) ? cur_limit : 16'($urandom_range(0, cur_limit));
        else if (cur_limit != 16'hFFFF)
          w = 16'($urandom_range(cur_limit + 1, 16'hFFFF));
        else
          w = 16'($urandom);
        frame[7] = w[15:8];
        frame[8] = w[7:0];
      end
      default: ;
    endcase
    crc = head_crc();
    if (kind == FK_BAD_CRC) crc = crc ^ (16'd1 << $urandom_range(0, 15));
    frame[CRC_SPAN]   = crc[7:0];
    frame[CRC_SPAN+1] = crc[15:8];
  endtask

  // offer one byte, called and returning at a falling edge
  task automatic send_byte(input byte_t b);
    if (!calm && $urandom_range(0, 6) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic send_frame(input frame_kind_t kind);
    build_frame(kind);
    for (int i = 0; i < FRAME_BYTES; i++) send_byte(frame[i]);
  endtask

  task automatic send_flat_frame(input byte_t b);
    for (int i = 0; i < FRAME_BYTES; i++) send_byte(b);
  endtask

  // drain all results, let the pipe settle, then write the speed limit
  task automatic settle_and_set_limit(input logic [15:0] v);
    s_axis_tvalid = 1'b0;
    while (reports_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    cur_limit = v;
  endtask

  task automatic send_mix(input int frames);
    for (int n = 0; n < frames; n++) send_frame(pick_kind());
  endtask

  // stimulus and verdict
  initial begin
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    calm          = 1'b0;
    hold_req      = 1'b0;
    cur_limit     = SPEED_LIMIT_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: byte extremes, command, count below three, every class, reset at nine
    settle_and_set_limit(SPEED_LIMIT_RESET);
    send_flat_frame(8'h00);
    send_flat_frame(8'hFF);
    send_frame(FK_COMMAND);
    send_frame(FK_BAD_CRC);
    send_frame(FK_STOPPED);
    send_frame(FK_STOPPED);
    send_frame(FK_OBSTRUCTED);
    send_frame(FK_NORMAL);
    send_frame(FK_SPEEDY);
    send_frame(FK_NORMAL);
    send_frame(FK_STOPPED);
    send_frame(FK_STOPPED);
    send_frame(FK_STOPPED);

    // random mixes under the limit extremes, long receiver hold-off in the first
    settle_and_set_limit(16'h0000);
    hold_req = 1'b1;
    send_mix(5);
    settle_and_set_limit(16'hFFFF);
    send_mix(5);
    settle_and_set_limit(16'($urandom));
    send_mix(5);

    // run of crc errors carries the count to eight or more without clearing it
    settle_and_set_limit(16'($urandom_range(0, 1023)));
    for (int n = 0; n < 8; n++) send_frame(FK_BAD_CRC);
    send_mix(4);

    // last stretch with no idling on either side
    settle_and_set_limit(16'($urandom));
    calm = 1'b1;
    send_mix(5);

    s_axis_tvalid = 1'b0;
    while (reports_due != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ modbus_frame_status_decoder_unit.f @@
rtl/core/mfsd_pkg.sv
rtl/core/mfsd_cell.sv
rtl/core/mfsd_judge.sv
rtl/core/modbus_frame_status_decoder_unit.sv
test/modbus_status_checker.sv
test/tb_modbus_frame_status_decoder_unit.sv
